>>> design/task_table_round_robin_assert.svh
// Assertion macros shared by the task table checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef TASK_TABLE_ROUND_ROBIN_ASSERT_SVH
`define TASK_TABLE_ROUND_ROBIN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TTRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("task table check failed");

// Next-cycle implication, disabled during reset.
`define TTRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("task table check failed");

`endif

>>> design/ttrr_pkg.sv
// Shared types and codes for the task table with round robin ready queue.
// No dependencies.
package ttrr_pkg;

  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_DESTROY = 3'd1;
  localparam logic [2:0] ACT_SET     = 3'd2;
  localparam logic [2:0] ACT_EXIT    = 3'd3;
  localparam logic [2:0] ACT_SCHED   = 3'd4;
  localparam logic [2:0] ACT_QUERY   = 3'd5;

  localparam logic [1:0] TS_READY      = 2'd0;
  localparam logic [1:0] TS_RUNNING    = 2'd1;
  localparam logic [1:0] TS_BLOCKED    = 2'd2;
  localparam logic [1:0] TS_TERMINATED = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFREE  = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;
  localparam logic [1:0] STAT_REFUSED = 2'd3;

  typedef enum logic [1:0] {
    TGT_PTR = 2'd0,
    TGT_CUR = 2'd1,
    TGT_SEL = 2'd2,
    TGT_RID = 2'd3
  } tgt_sel_t;

  typedef enum logic [1:0] {
    RID_TGT  = 2'd0,
    RID_CUR  = 2'd1,
    RID_ZERO = 2'd2
  } rid_sel_t;

  typedef struct packed {
    logic       load;
    logic       tgt_ld;
    tgt_sel_t   tgt_sel;
    logic       rd;
    logic       unlink;
    logic       enq1;
    logic       enq2;
    logic       st_wr;
    logic       st_nst;
    logic [1:0] st_val;
    logic       par_wr;
    logic       par_cur;
    logic       used_set;
    logic       used_clr;
    logic       srch_init;
    logic       srch_step;
    logic       search_ld;
    logic       sel_ld;
    logic       cur_ld;
    logic       rid_ld;
    rid_sel_t   rid_sel;
    logic       stat_ld;
    logic [1:0] stat_val;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       tgt_valid;
    logic       tgt_is0;
    logic       tgt_is_cur;
    logic       cur_is0;
    logic       old_ready;
    logic       nst_ready;
    logic       head_none;
    logic       sel_is_cur;
    logic       srch_free;
    logic       srch_end;
    logic       out_full;
  } sts_t;

endpackage

>>> design/ttrr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ttrr_ram #(
  parameter int W = 8,
  parameter int D = 64,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  q
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem_r[raddr];
    end
  end

  assign q = q_r;

endmodule

>>> design/ttrr_ctrl.sv
// Sequencing state machine for the task table.
// Depends on ttrr_pkg for the command and status structs.
module ttrr_ctrl import ttrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'd1,
    S_DEC   = 18'd2,
    S_SRCH  = 18'd4,
    S_CWR   = 18'd8,
    S_DWAIT = 18'd16,
    S_SWAIT = 18'd32,
    S_ENQ1  = 18'd64,
    S_ENQ2  = 18'd128,
    S_XWAIT = 18'd256,
    S_SCH0  = 18'd512,
    S_SCH1  = 18'd1024,
    S_SQ1   = 18'd2048,
    S_SQ2   = 18'd4096,
    S_SW    = 18'd8192,
    S_SW2   = 18'd16384,
    S_SEND  = 18'd32768,
    S_ORD   = 18'd65536,
    S_OUT   = 18'd131072
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.act)
          ACT_CREATE: begin
            cmd.srch_init = 1'b1;
            state_nxt = S_SRCH;
          end
          ACT_DESTROY: begin
            if (!sts.tgt_valid) begin
              cmd.stat_ld = 1'b1;
              cmd.stat_val = STAT_BAD;
              state_nxt = S_ORD;
            end else if (sts.tgt_is0 || sts.tgt_is_cur) begin
              cmd.stat_ld = 1'b1;
              cmd.stat_val = STAT_REFUSED;
              state_nxt = S_ORD;
            end else begin
              cmd.rd = 1'b1;
              state_nxt = S_DWAIT;
            end
          end
          ACT_SET: begin
            if (!sts.tgt_valid) begin
              cmd.stat_ld = 1'b1;
              cmd.stat_val = STAT_BAD;
              state_nxt = S_ORD;
            end else begin
              cmd.rd = 1'b1;
              state_nxt = S_SWAIT;
            end
          end
          ACT_EXIT: begin
            cmd.rid_ld = 1'b1;
            cmd.rid_sel = RID_CUR;
            if (sts.cur_is0) begin
              cmd.stat_ld = 1'b1;
              cmd.stat_val = STAT_REFUSED;
              state_nxt = S_ORD;
            end else begin
              cmd.tgt_ld = 1'b1;
              cmd.tgt_sel = TGT_CUR;
              cmd.rd = 1'b1;
              state_nxt = S_XWAIT;
            end
          end
          ACT_SCHED: begin
            state_nxt = S_SCH0;
          end
          ACT_QUERY: begin
            if (!sts.tgt_valid) begin
              cmd.stat_ld = 1'b1;
              cmd.stat_val = STAT_BAD;
            end
            state_nxt = S_ORD;
          end
          default: begin
            cmd.stat_ld = 1'b1;
            cmd.stat_val = STAT_REFUSED;
            state_nxt = S_ORD;
          end
        endcase
      end
      S_SRCH: begin
        if (sts.srch_end) begin
          cmd.stat_ld = 1'b1;
          cmd.stat_val = STAT_NOFREE;
          cmd.rid_ld = 1'b1;
          cmd.rid_sel = RID_ZERO;
          state_nxt = S_ORD;
        end else if (sts.srch_free) begin
          cmd.tgt_ld = 1'b1;
          cmd.tgt_sel = TGT_PTR;
          state_nxt = S_CWR;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_CWR: begin
        cmd.used_set = 1'b1;
        cmd.st_wr = 1'b1;
        cmd.st_val = TS_READY;
        cmd.par_wr = 1'b1;
        cmd.par_cur = 1'b1;
        cmd.search_ld = 1'b1;
        cmd.rid_ld = 1'b1;
        cmd.rid_sel = RID_TGT;
        state_nxt = S_ENQ1;
      end
      S_DWAIT: begin
        cmd.unlink = 1'b1;
        cmd.used_clr = 1'b1;
        cmd.st_wr = 1'b1;
        cmd.st_val = TS_READY;
        cmd.par_wr = 1'b1;
        state_nxt = S_ORD;
      end
      S_SWAIT: begin
        cmd.st_wr = 1'b1;
        cmd.st_nst = 1'b1;
        if (sts.old_ready && !sts.nst_ready) begin
          cmd.unlink = 1'b1;
          state_nxt = S_ORD;
        end else if (!sts.old_ready && sts.nst_ready) begin
          state_nxt = S_ENQ1;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_ENQ1: begin
        cmd.enq1 = 1'b1;
        state_nxt = S_ENQ2;
      end
      S_ENQ2: begin
        cmd.enq2 = 1'b1;
        state_nxt = S_ORD;
      end
      S_XWAIT: begin
        cmd.st_wr = 1'b1;
        cmd.st_val = TS_TERMINATED;
        cmd.unlink = 1'b1;
        state_nxt = S_SCH0;
      end
      S_SCH0: begin
        if (sts.head_none) begin
          state_nxt = S_SEND;
        end else begin
          cmd.sel_ld = 1'b1;
          cmd.tgt_ld = 1'b1;
          cmd.tgt_sel = TGT_CUR;
          cmd.rd = 1'b1;
          state_nxt = S_SCH1;
        end
      end
      S_SCH1: begin
        if (sts.old_ready) begin
          cmd.unlink = 1'b1;
          state_nxt = S_SQ1;
        end else begin
          state_nxt = S_SW;
        end
      end
      S_SQ1: begin
        cmd.enq1 = 1'b1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.enq2 = 1'b1;
        state_nxt = S_SW;
      end
      S_SW: begin
        if (sts.sel_is_cur) begin
          state_nxt = S_SEND;
        end else begin
          cmd.cur_ld = 1'b1;
          cmd.tgt_ld = 1'b1;
          cmd.tgt_sel = TGT_SEL;
          cmd.rd = 1'b1;
          state_nxt = S_SW2;
        end
      end
      S_SW2: begin
        cmd.st_wr = 1'b1;
        cmd.st_val = TS_RUNNING;
        cmd.unlink = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (sts.act != ACT_EXIT) begin
          cmd.rid_ld = 1'b1;
          cmd.rid_sel = RID_CUR;
        end
        state_nxt = S_ORD;
      end
      S_ORD: begin
        cmd.tgt_ld = 1'b1;
        cmd.tgt_sel = TGT_RID;
        cmd.rd = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_ld = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/ttrr_dpath.sv
// Datapath of the task table: slot flags, queue pointers, link and attribute
// memories, free-slot search and result register. Depends on ttrr_pkg, ttrr_ram.
module ttrr_dpath import ttrr_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_action,
  input  logic [5:0] in_task_id,
  input  logic [1:0] in_new_state,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [5:0] out_result_id,
  output logic       out_slot_in_use,
  output logic [1:0] out_slot_state,
  output logic [5:0] out_slot_parent,
  output logic [5:0] out_current_id,
  output logic       out_queue_empty
);

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int IW = $clog2(TASK_SLOTS + 1);
  localparam int TW = (IW > 6) ? IW : 6;
  localparam logic [IW-1:0] NONE = IW'(TASK_SLOTS);

  logic [TASK_SLOTS-1:0] used_r, used_nxt, queued_r, queued_nxt;
  logic [TASK_SLOTS-1:0] wvs_r, wvs_nxt, wvp_r, wvp_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt, search_r, search_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt, sel_r, sel_nxt, ptr_r, ptr_nxt;
  logic [TW-1:0] tgt_r, tgt_nxt, rid_r, rid_nxt;
  logic [2:0]    act_r;
  logic [1:0]    nst_r, status_r;
  logic          wvsq_r, wvpq_r, z0q_r;
  logic          out_valid_r;
  logic [1:0]    o_status_r, o_state_r;
  logic [5:0]    o_rid_r, o_parent_r, o_cur_r;
  logic          o_used_r, o_empty_r;

  logic          tgt_in, rd_in;
  logic [AW-1:0] ta, raddr;
  logic [1:0]    st_q, st_wd, rd_state;
  logic [AW-1:0] par_q, par_wd, rd_parent;
  logic [IW-1:0] nl_q, pl_q, nl_wd, pl_wd;
  logic [AW-1:0] nl_wa, pl_wa;
  logic          nl_we, pl_we;
  logic [TW-1:0] par_ext, cur_ext;

  assign tgt_in = tgt_r < TW'(TASK_SLOTS);
  assign ta     = tgt_in ? tgt_r[AW-1:0] : '0;

  always_comb begin
    tgt_nxt = tgt_r;
    if (cmd.load) begin
      tgt_nxt = TW'(in_task_id);
    end else if (cmd.tgt_ld) begin
      case (cmd.tgt_sel)
        TGT_PTR: tgt_nxt = TW'(ptr_r);
        TGT_CUR: tgt_nxt = TW'(cur_r);
        TGT_SEL: tgt_nxt = TW'(sel_r);
        TGT_RID: tgt_nxt = rid_r;
        default: tgt_nxt = tgt_r;
      endcase
    end
  end

  assign rd_in = tgt_nxt < TW'(TASK_SLOTS);
  assign raddr = rd_in ? tgt_nxt[AW-1:0] : '0;

  // Entries never written read as their reset values.
  assign rd_state  = wvsq_r ? st_q : (z0q_r ? TS_RUNNING : TS_READY);
  assign rd_parent = wvpq_r ? par_q : '0;
  assign st_wd     = cmd.st_nst ? nst_r : cmd.st_val;
  assign par_wd    = cmd.par_cur ? cur_r : '0;

  always_comb begin
    used_nxt   = used_r;
    queued_nxt = queued_r;
    wvs_nxt    = wvs_r;
    wvp_nxt    = wvp_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    nl_we = 1'b0;
    pl_we = 1'b0;
    nl_wa = ta;
    pl_wa = ta;
    nl_wd = NONE;
    pl_wd = NONE;
    if (cmd.unlink && queued_r[ta]) begin
      if (pl_q < NONE) begin
        nl_we = 1'b1;
        nl_wa = pl_q[AW-1:0];
        nl_wd = nl_q;
      end else begin
        head_nxt = nl_q;
      end
      if (nl_q < NONE) begin
        pl_we = 1'b1;
        pl_wa = nl_q[AW-1:0];
        pl_wd = pl_q;
      end else begin
        tail_nxt = pl_q;
      end
      queued_nxt[ta] = 1'b0;
    end
    if (cmd.enq1 && !queued_r[ta]) begin
      nl_we = 1'b1;
      nl_wd = NONE;
      pl_we = 1'b1;
      pl_wd = tail_r;
    end
    if (cmd.enq2 && !queued_r[ta]) begin
      if (tail_r < NONE) begin
        nl_we = 1'b1;
        nl_wa = tail_r[AW-1:0];
        nl_wd = IW'(ta);
      end else begin
        head_nxt = IW'(ta);
      end
      tail_nxt = IW'(ta);
      queued_nxt[ta] = 1'b1;
    end
    if (cmd.used_set) used_nxt[ta] = 1'b1;
    if (cmd.used_clr) used_nxt[ta] = 1'b0;
    if (cmd.st_wr)    wvs_nxt[ta] = 1'b1;
    if (cmd.par_wr)   wvp_nxt[ta] = 1'b1;
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    search_nxt = search_r;
    cur_nxt    = cur_r;
    sel_nxt    = sel_r;
    rid_nxt    = rid_r;
    if (cmd.srch_init) begin
      ptr_nxt = (search_r >= NONE) ? AW'(1) : search_r[AW-1:0];
      cnt_nxt = '0;
    end else if (cmd.srch_step) begin
      ptr_nxt = (ptr_r == AW'(TASK_SLOTS - 1)) ? AW'(1) : ptr_r + AW'(1);
      cnt_nxt = cnt_r + IW'(1);
    end
    if (cmd.search_ld) search_nxt = IW'(ta) + IW'(1);
    if (cmd.sel_ld)    sel_nxt = head_r[AW-1:0];
    if (cmd.cur_ld)    cur_nxt = sel_r;
    if (cmd.load) begin
      rid_nxt = TW'(in_task_id);
    end else if (cmd.rid_ld) begin
      case (cmd.rid_sel)
        RID_TGT:  rid_nxt = tgt_r;
        RID_CUR:  rid_nxt = TW'(cur_r);
        RID_ZERO: rid_nxt = '0;
        default:  rid_nxt = rid_r;
      endcase
    end
  end

  ttrr_ram #(.W(2), .D(TASK_SLOTS)) u_state_ram (
    .clk(clk), .we(cmd.st_wr), .waddr(ta), .wdata(st_wd),
    .re(cmd.rd), .raddr(raddr), .q(st_q)
  );
  ttrr_ram #(.W(AW), .D(TASK_SLOTS)) u_parent_ram (
    .clk(clk), .we(cmd.par_wr), .waddr(ta), .wdata(par_wd),
    .re(cmd.rd), .raddr(raddr), .q(par_q)
  );
  ttrr_ram #(.W(IW), .D(TASK_SLOTS)) u_next_ram (
    .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd),
    .re(cmd.rd), .raddr(raddr), .q(nl_q)
  );
  ttrr_ram #(.W(IW), .D(TASK_SLOTS)) u_prev_ram (
    .clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd),
    .re(cmd.rd), .raddr(raddr), .q(pl_q)
  );

  assign par_ext = TW'(rd_parent);
  assign cur_ext = TW'(cur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= TASK_SLOTS'(1);
      queued_r    <= '0;
      wvs_r       <= '0;
      wvp_r       <= '0;
      head_r      <= NONE;
      tail_r      <= NONE;
      search_r    <= IW'(1);
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      queued_r <= queued_nxt;
      wvs_r    <= wvs_nxt;
      wvp_r    <= wvp_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      search_r <= search_nxt;
      cur_r    <= cur_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    rid_r <= rid_nxt;
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
    sel_r <= sel_nxt;
    if (cmd.load) begin
      act_r    <= in_action;
      nst_r    <= in_new_state;
      status_r <= STAT_OK;
    end else if (cmd.stat_ld) begin
      status_r <= cmd.stat_val;
    end
    if (cmd.rd) begin
      wvsq_r <= wvs_r[raddr];
      wvpq_r <= wvp_r[raddr];
      z0q_r  <= (raddr == '0);
    end
    if (cmd.out_ld) begin
      o_status_r <= status_r;
      o_rid_r    <= rid_r[5:0];
      o_used_r   <= tgt_in && used_r[ta];
      o_state_r  <= tgt_in ? rd_state : TS_READY;
      o_parent_r <= tgt_in ? par_ext[5:0] : 6'd0;
      o_cur_r    <= cur_ext[5:0];
      o_empty_r  <= head_r >= NONE;
    end
  end

  always_comb begin
    sts.act        = act_r;
    sts.tgt_valid  = tgt_in && used_r[ta];
    sts.tgt_is0    = (tgt_r == '0);
    sts.tgt_is_cur = (tgt_r == cur_ext);
    sts.cur_is0    = (cur_r == '0);
    sts.old_ready  = (rd_state == TS_READY);
    sts.nst_ready  = (nst_r == TS_READY);
    sts.head_none  = (head_r >= NONE);
    sts.sel_is_cur = (sel_r == cur_r);
    sts.srch_free  = !used_r[ptr_r];
    sts.srch_end   = (cnt_r == IW'(TASK_SLOTS - 1));
    sts.out_full   = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_result_id   = o_rid_r;
  assign out_slot_in_use = o_used_r;
  assign out_slot_state  = o_state_r;
  assign out_slot_parent = o_parent_r;
  assign out_current_id  = o_cur_r;
  assign out_queue_empty = o_empty_r;

endmodule

>>> design/task_table_round_robin.sv
// Top level of the task table with round robin ready queue.
// Depends on ttrr_pkg, ttrr_ctrl and ttrr_dpath.
//
// Usage: each input transaction (in_action, in_task_id, in_new_state) is one
// request: create, destroy, set state, exit, schedule or query. Each request
// produces exactly one result transaction on the out_ channel, in order.
// The block works on one request at a time; in_ready is high only while the
// sequencer is idle. Set state takes longer when it appends the task to the
// queue, and exit and schedule take longer when the ready queue is not empty.
// Create scans the slot table one slot per cycle, next-fit from the last
// allocation. The next request is accepted the cycle after the result is
// registered. The free-slot scan and the single port link memories set how
// long each request takes.
// The result sits in an output register, so the next request is accepted as
// soon as the result has been registered, even while out_ready is low. If the
// receiver stalls, the following result waits in the sequencer until the
// register is free.
// After reset slot 0 holds the idle task, running and current, the ready
// queue is empty and the block is ready at once; no clearing pass is needed.
module task_table_round_robin import ttrr_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [5:0] in_task_id,
  input  logic [1:0] in_new_state,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [5:0] out_result_id,
  output logic       out_slot_in_use,
  output logic [1:0] out_slot_state,
  output logic [5:0] out_slot_parent,
  output logic [5:0] out_current_id,
  output logic       out_queue_empty
);

  // Command and status travel between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  ttrr_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts(sts),
    .cmd(cmd)
  );

  // The datapath holds the slot flags, queue pointers and link memories.
  ttrr_dpath #(.TASK_SLOTS(TASK_SLOTS)) u_dpath (
    .clk(clk),
    .rst_n(rst_n),
    .in_action(in_action),
    .in_task_id(in_task_id),
    .in_new_state(in_new_state),
    .cmd(cmd),
    .sts(sts),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_result_id(out_result_id),
    .out_slot_in_use(out_slot_in_use),
    .out_slot_state(out_slot_state),
    .out_slot_parent(out_slot_parent),
    .out_current_id(out_current_id),
    .out_queue_empty(out_queue_empty)
  );

endmodule

>>> design/ttrr_checker.sv
// Port-level checks for the task table, bound to the top level.
// Depends on ttrr_pkg and task_table_round_robin_assert.svh.
`include "task_table_round_robin_assert.svh"
module ttrr_checker import ttrr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_action,
  input logic [5:0] in_task_id,
  input logic [1:0] in_new_state,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [5:0] out_result_id,
  input logic       out_slot_in_use,
  input logic [1:0] out_slot_state,
  input logic [5:0] out_slot_parent,
  input logic [5:0] out_current_id,
  input logic       out_queue_empty
);

  // One request at a time: the sequencer is busy right after a transaction.
  `TTRR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // A free slot always reads as a ready task with no parent.
  `TTRR_ASSERT_IMP(a_free_slot_clear, out_valid && !out_slot_in_use,
    out_slot_state == TS_READY && out_slot_parent == 6'd0)
  // A failed allocation reports id zero.
  `TTRR_ASSERT_IMP(a_nofree_id, out_valid && out_status == STAT_NOFREE,
    out_result_id == 6'd0)
  // A stalled result stays offered.
  `TTRR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind task_table_round_robin ttrr_checker u_ttrr_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the task table with round robin ready queue.
// Depends on ttrr_pkg and the task_table_round_robin RTL; it reads no files.
module testbench import ttrr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int NONE = SLOTS;
  localparam int STALL_LIMIT = 4000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_action = '0;
  logic [5:0] in_task_id = '0;
  logic [1:0] in_new_state = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_result_id;
  logic       out_slot_in_use;
  logic [1:0] out_slot_state;
  logic [5:0] out_slot_parent;
  logic [5:0] out_current_id;
  logic       out_queue_empty;

  // One expected result, held field by field.
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] rid;
    logic       in_use;
    logic [1:0] state;
    logic [5:0] parent;
    logic [5:0] cur;
    logic       qempty;
  } task_result_t;

  task_result_t pending_results[$];
  int  error_count = 0;
  int  sent_count = 0;
  int  got_count = 0;
  int  idle_cycles = 0;
  bit  hold_receiver = 1'b0;

  // The predictor's own copy of the task table and its ready queue.
  bit       tbl_used[SLOTS];
  bit [1:0] tbl_state[SLOTS];
  bit [5:0] tbl_parent[SLOTS];
  bit       tbl_queued[SLOTS];
  int       q_next[SLOTS];
  int       q_prev[SLOTS];
  int       q_head, q_tail, running_id, next_fit;

  task_table_round_robin #(.TASK_SLOTS(SLOTS)) dut (.*);

  always #5 clk = ~clk;

  // Appends a task to the tail of the ready queue unless it is already there.
  function automatic void queue_append(int t);
    if (tbl_queued[t]) return;
    q_prev[t] = q_tail;
    q_next[t] = NONE;
    if (q_tail < SLOTS) q_next[q_tail] = t;
    else q_head = t;
    q_tail = t;
    tbl_queued[t] = 1'b1;
  endfunction

  // Removing a task that is not queued must leave the queue untouched.
  function automatic void queue_remove(int t);
    int p, n;
    if (!tbl_queued[t]) return;
    p = q_prev[t];
    n = q_next[t];
    if (p < SLOTS) q_next[p] = n;
    else q_head = n;
    if (n < SLOTS) q_prev[n] = p;
    else q_tail = p;
    tbl_queued[t] = 1'b0;
  endfunction

  // Round robin switch: a ready current task rotates to the tail first, and a
  // head equal to the current task causes no switch.
  function automatic void switch_task();
    int nxt;
    if (q_head >= SLOTS) return;
    nxt = q_head;
    if (tbl_state[running_id] == TS_READY) begin
      queue_remove(running_id);
      queue_append(running_id);
    end
    if (nxt != running_id) begin
      running_id = nxt;
      tbl_state[nxt] = TS_RUNNING;
      queue_remove(nxt);
    end
  endfunction

  function automatic int find_free_slot();
    for (int i = next_fit; i < SLOTS; i++) if (!tbl_used[i]) return i;
    for (int i = 1; i < next_fit && i < SLOTS; i++) if (!tbl_used[i]) return i;
    return NONE;
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_state[i] = TS_READY;
      tbl_parent[i] = '0;
      tbl_queued[i] = 1'b0;
      q_next[i] = NONE;
      q_prev[i] = NONE;
    end
    tbl_used[0] = 1'b1;
    tbl_state[0] = TS_RUNNING;
    q_head = NONE;
    q_tail = NONE;
    running_id = 0;
    next_fit = 1;
  endfunction

  // Applies one request to the predicted table and returns the result.
  function automatic task_result_t apply_request(logic [2:0] act, logic [5:0] tid,
                                                 logic [1:0] nst);
    task_result_t r;
    int  rid, f;
    bit  ok;
    logic [1:0] old;
    r = '0;
    rid = tid;
    ok = tbl_used[tid];
    r.status = STAT_OK;
    case (act)
      ACT_CREATE: begin
        f = find_free_slot();
        if (f >= SLOTS) begin
          r.status = STAT_NOFREE;
          rid = 0;
        end else begin
          next_fit = f + 1;
          tbl_used[f] = 1'b1;
          tbl_state[f] = TS_READY;
          tbl_parent[f] = running_id[5:0];
          queue_append(f);
          rid = f;
        end
      end
      ACT_DESTROY: begin
        if (!ok) r.status = STAT_BAD;
        else if (tid == 0 || tid == running_id) r.status = STAT_REFUSED;
        else begin
          queue_remove(tid);
          tbl_used[tid] = 1'b0;
          tbl_state[tid] = TS_READY;
          tbl_parent[tid] = '0;
        end
      end
      ACT_SET: begin
        if (!ok) r.status = STAT_BAD;
        else begin
          old = tbl_state[tid];
          tbl_state[tid] = nst;
          if (old == TS_READY && nst != TS_READY) queue_remove(tid);
          else if (old != TS_READY && nst == TS_READY) queue_append(tid);
        end
      end
      ACT_EXIT: begin
        rid = running_id;
        if (running_id == 0) r.status = STAT_REFUSED;
        else begin
          tbl_state[running_id] = TS_TERMINATED;
          queue_remove(running_id);
          switch_task();
        end
      end
      ACT_SCHED: begin
        switch_task();
        rid = running_id;
      end
      ACT_QUERY: if (!ok) r.status = STAT_BAD;
      default: r.status = STAT_REFUSED;
    endcase
    r.rid = rid[5:0];
    r.in_use = tbl_used[rid];
    r.state = tbl_state[rid];
    r.parent = tbl_parent[rid];
    r.cur = running_id[5:0];
    r.qempty = (q_head >= SLOTS);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s is %0d, expected %0d", got_count, what, got, want);
    error_count++;
  endtask

  // Sends one request after a random gap; the predictor runs on acceptance.
  // With no gap, valid simply stays high into the next request.
  task automatic send_request(logic [2:0] act, logic [5:0] tid, logic [1:0] nst);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_task_id <= tid;
    in_new_state <= nst;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(act, tid, nst));
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver: waits a random number of cycles before each result, and holds
  // off completely while the long stall is in force.
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 7);
      if (gap > 0 || hold_receiver) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        while (hold_receiver) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Result checker: compares every accepted transaction with the oldest one due.
  always @(posedge clk) begin
    task_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result transaction, result_id %0d", out_result_id);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_result_id !== e.rid) report_mismatch("result_id", out_result_id, e.rid);
        if (out_slot_in_use !== e.in_use)
          report_mismatch("slot_in_use", out_slot_in_use, e.in_use);
        if (out_slot_state !== e.state) report_mismatch("slot_state", out_slot_state, e.state);
        if (out_slot_parent !== e.parent)
          report_mismatch("slot_parent", out_slot_parent, e.parent);
        if (out_current_id !== e.cur) report_mismatch("current_id", out_current_id, e.cur);
        if (out_queue_empty !== e.qempty)
          report_mismatch("queue_empty", out_queue_empty, e.qempty);
      end
      got_count++;
    end
  end

  // Watchdog: the limit covers a full create scan behind a long receiver stall.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_receiver) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Picks a target that is usually in use, so that requests go deep.
  function automatic logic [5:0] pick_target();
    int t;
    if ($urandom_range(0, 9) < 2) return 6'($urandom_range(0, SLOTS - 1));
    for (int k = 0; k < 8; k++) begin
      t = $urandom_range(0, 15);
      if (tbl_used[t]) return t[5:0];
    end
    return 6'($urandom_range(0, 15));
  endfunction

  // Directed opening: extremes, every operation and each refusal.
  task automatic test_directed();
    send_request(ACT_QUERY, 6'd0, TS_READY);
    send_request(ACT_QUERY, 6'd63, TS_TERMINATED);
    send_request(ACT_EXIT, 6'd0, TS_READY);
    send_request(ACT_DESTROY, 6'd0, TS_READY);
    send_request(ACT_DESTROY, 6'd63, TS_READY);
    send_request(ACT_SCHED, 6'd0, TS_READY);
    send_request(ACT_CREATE, 6'd0, TS_READY);
    send_request(ACT_CREATE, 6'd0, TS_READY);
    send_request(ACT_SET, 6'd0, TS_READY);
    send_request(ACT_SCHED, 6'd0, TS_READY);
    send_request(ACT_DESTROY, 6'd1, TS_READY);
    send_request(ACT_SET, 6'd2, TS_BLOCKED);
    send_request(ACT_SET, 6'd2, TS_BLOCKED);
    send_request(ACT_SET, 6'd2, TS_READY);
    send_request(ACT_SET, 6'd63, TS_RUNNING);
    send_request(ACT_EXIT, 6'd0, TS_READY);
    send_request(ACT_DESTROY, 6'd2, TS_READY);
    send_request(3'd6, 6'd5, TS_RUNNING);
    send_request(3'd7, 6'd63, TS_TERMINATED);
    send_request(ACT_SCHED, 6'd0, TS_READY);
    send_request(ACT_QUERY, 6'd1, TS_READY);
  endtask

  // Fills the table completely, then hits the no-free-id case and wrap-around.
  task automatic test_full_table();
    while (find_free_slot() != NONE) send_request(ACT_CREATE, 6'($urandom), 2'($urandom));
    send_request(ACT_CREATE, 6'd0, TS_READY);
    send_request(ACT_SET, 6'd63, TS_TERMINATED);
    send_request(ACT_DESTROY, 6'd63, TS_READY);
    send_request(ACT_DESTROY, 6'd3, TS_READY);
    send_request(ACT_CREATE, 6'd0, TS_READY);
    send_request(ACT_CREATE, 6'd0, TS_READY);
  endtask

  // Trims the table back so that random traffic has free slots again.
  task automatic test_release();
    for (int i = 1; i < SLOTS; i++)
      if (tbl_used[i] && i != running_id && $urandom_range(0, 3) != 0)
        send_request(ACT_DESTROY, 6'(i), TS_READY);
  endtask

  // The receiver holds off while requests keep coming, so the output fills.
  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1'b1;
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
      repeat (6) send_request(ACT_QUERY, pick_target(), TS_READY);
    join
  endtask

  // Mostly well-formed traffic on live tasks, with some noise requests.
  task automatic test_random(int count);
    logic [2:0] act;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 22) act = (find_free_slot() == NONE) ? ACT_DESTROY : ACT_CREATE;
      else if (roll < 34) act = ACT_DESTROY;
      else if (roll < 54) act = ACT_SET;
      else if (roll < 64) act = ACT_EXIT;
      else if (roll < 84) act = ACT_SCHED;
      else if (roll < 97) act = ACT_QUERY;
      else act = 3'($urandom_range(6, 7));
      send_request(act, roll < 3 ? 6'($urandom) : pick_target(), 2'($urandom));
    end
  endtask

  initial begin
    table_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_release();
    test_backpressure();
    test_random(1900);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests and checked %0d results, including a full table,", sent_count,
             got_count);
    $display("a long receiver stall and random create, destroy and scheduling traffic.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/ttrr_pkg.sv
design/ttrr_ram.sv
design/ttrr_ctrl.sv
design/ttrr_dpath.sv
design/task_table_round_robin.sv
design/ttrr_checker.sv
sim/testbench.sv
